[hdl/rlf_pkg.sv]
// rlf_pkg: shared types and fixed-point constants for the RGB linear fader.
// Used by rlf_channel and rgb_linear_fader; depends on nothing.
`default_nettype none

package rlf_pkg;

   localparam int unsigned FRAC_BITS  = 16;
   localparam int unsigned FADE_STEPS = 255;

   localparam int unsigned LVL_W = 8 + FRAC_BITS;

   localparam logic [LVL_W-1:0] LVL_MAX  = {8'hFF, {FRAC_BITS{1'b0}}};
   localparam logic [LVL_W-1:0] LVL_HALF = LVL_W'(1) << (FRAC_BITS - 1);

   localparam int unsigned RATE_W =
      $clog2(((longint'(255) << FRAC_BITS) / FADE_STEPS) + 1);

   // floor(x / FADE_STEPS) == (x * RECIP) >> DIV_SHIFT for every x below 2^LVL_W
   localparam int unsigned DIV_SHIFT = LVL_W + $clog2(FADE_STEPS);
   localparam int unsigned RECIP_W   = LVL_W + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((longint'(1) << DIV_SHIFT) + FADE_STEPS - 1) / FADE_STEPS);
   localparam int unsigned PROD_W    = LVL_W + RECIP_W;

   typedef enum logic [1:0] {
      OP_SET  = 2'd0,
      OP_FADE = 2'd1,
      OP_READ = 2'd2,
      OP_TICK = 2'd3
   } op_type;

   typedef struct packed {
      logic   enable;
      op_type op;
   } ctl_type;

endpackage

`default_nettype wire

[hdl/rlf_channel.sv]
// rlf_channel: one color channel: current level, target and step rate registers,
// with the set, fade and tick updates. Depends on rlf_pkg.
`default_nettype none

module rlf_channel (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rlf_pkg::ctl_type ctl,
   input  wire logic [7:0]       value,
   output logic      [7:0]       level,
   output logic                  moved
);

   logic [rlf_pkg::LVL_W-1:0]  cur_ff, cur_in;
   logic [7:0]                 tgt_ff, tgt_in;
   logic [rlf_pkg::RATE_W-1:0] rate_ff, rate_in;

   logic [rlf_pkg::LVL_W-1:0]  tgt_fix;
   logic [rlf_pkg::LVL_W-1:0]  diff;
   logic [rlf_pkg::PROD_W-1:0] prod;
   logic [rlf_pkg::LVL_W-1:0]  cur_rnd;
   logic [7:0]                 rnd_now;
   logic [rlf_pkg::LVL_W:0]    up_sum;
   logic [rlf_pkg::LVL_W-1:0]  cur_up;
   logic [rlf_pkg::LVL_W-1:0]  cur_dn;
   logic [rlf_pkg::LVL_W-1:0]  rate_ext;
   logic [rlf_pkg::LVL_W-1:0]  next_rnd;

   assign tgt_fix  = {value, {rlf_pkg::FRAC_BITS{1'b0}}};
   assign diff     = (cur_ff > tgt_fix) ? (cur_ff - tgt_fix) : (tgt_fix - cur_ff);
   assign prod     = rlf_pkg::PROD_W'(diff) * rlf_pkg::PROD_W'(rlf_pkg::RECIP);

   assign cur_rnd  = cur_ff + rlf_pkg::LVL_HALF;
   assign rnd_now  = cur_rnd[rlf_pkg::LVL_W-1:rlf_pkg::FRAC_BITS];

   assign rate_ext = rlf_pkg::LVL_W'(rate_ff);
   assign up_sum   = {1'b0, cur_ff} + {1'b0, rate_ext};
   assign cur_up   = (up_sum > {1'b0, rlf_pkg::LVL_MAX}) ?
                     rlf_pkg::LVL_MAX : up_sum[rlf_pkg::LVL_W-1:0];
   assign cur_dn   = (cur_ff > rate_ext) ? (cur_ff - rate_ext) : '0;

   always_comb begin
      cur_in  = cur_ff;
      tgt_in  = tgt_ff;
      rate_in = rate_ff;
      moved   = 1'b0;
      case (ctl.op)
         rlf_pkg::OP_SET: begin
            cur_in = tgt_fix;
            tgt_in = value;
         end
         rlf_pkg::OP_FADE: begin
            rate_in = rlf_pkg::RATE_W'(prod >> rlf_pkg::DIV_SHIFT);
            tgt_in  = value;
         end
         rlf_pkg::OP_TICK: begin
            if (rnd_now > tgt_ff) begin
               cur_in = cur_dn;
               moved  = 1'b1;
            end else if (rnd_now < tgt_ff) begin
               cur_in = cur_up;
               moved  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign next_rnd = cur_in + rlf_pkg::LVL_HALF;
   assign level    = (ctl.op == rlf_pkg::OP_READ) ?
                     cur_ff[rlf_pkg::LVL_W-1:rlf_pkg::FRAC_BITS] :
                     next_rnd[rlf_pkg::LVL_W-1:rlf_pkg::FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         tgt_ff  <= '0;
         rate_ff <= '0;
      end else if (ctl.enable) begin
         cur_ff  <= cur_in;
         tgt_ff  <= tgt_in;
         rate_ff <= rate_in;
      end
   end

endmodule

`default_nettype wire

[hdl/rgb_linear_fader.sv]
// rgb_linear_fader: top level with the request register, three channels and
// the response register. Depends on rlf_pkg and rlf_channel.
//
// Three-channel linear LED fader. Each transaction (set, fade, read or tick)
// yields exactly one response, held first in the request register and then in
// the response register, and a new transaction is accepted every cycle while
// the response side keeps up. On the fade path the per-channel rate
// |current - target| / FADE_STEPS is a single reciprocal multiply, done
// combinationally between the request register and the channel state and
// response registers. A response waiting under rsp_stall holds one request in
// the input register; req_stall rises only when both registers are full.
`default_nettype none

module rgb_linear_fader (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_op,
   input  wire logic [7:0] req_red_in,
   input  wire logic [7:0] req_green_in,
   input  wire logic [7:0] req_blue_in,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_red_level,
   output logic [7:0]      rsp_green_level,
   output logic [7:0]      rsp_blue_level,
   output logic            rsp_drive_update,
   output logic            rsp_is_read_reply
);

   logic             in_valid_ff;
   rlf_pkg::op_type  op_ff;
   logic [7:0]       red_ff, green_ff, blue_ff;

   logic             out_valid_ff;
   logic [7:0]       red_lvl_ff, green_lvl_ff, blue_lvl_ff;
   logic             drive_ff, read_ff;

   logic             advance;
   rlf_pkg::ctl_type ctl;
   logic [7:0]       red_lvl, green_lvl, blue_lvl;
   logic             red_moved, green_moved, blue_moved;
   logic             drive_in;

   assign advance    = !out_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !advance;
   assign ctl.enable = in_valid_ff && advance;
   assign ctl.op     = op_ff;

   rlf_channel u_red (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .value (red_ff),
      .level (red_lvl),
      .moved (red_moved)
   );

   rlf_channel u_green (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .value (green_ff),
      .level (green_lvl),
      .moved (green_moved)
   );

   rlf_channel u_blue (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .value (blue_ff),
      .level (blue_lvl),
      .moved (blue_moved)
   );

   assign drive_in = (op_ff == rlf_pkg::OP_SET) ||
                     ((op_ff == rlf_pkg::OP_TICK) && (red_moved || green_moved || blue_moved));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         op_ff    <= rlf_pkg::op_type'(req_op);
         red_ff   <= req_red_in;
         green_ff <= req_green_in;
         blue_ff  <= req_blue_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable) begin
         red_lvl_ff   <= red_lvl;
         green_lvl_ff <= green_lvl;
         blue_lvl_ff  <= blue_lvl;
         drive_ff     <= drive_in;
         read_ff      <= (op_ff == rlf_pkg::OP_READ);
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_red_level     = red_lvl_ff;
   assign rsp_green_level   = green_lvl_ff;
   assign rsp_blue_level    = blue_lvl_ff;
   assign rsp_drive_update  = drive_ff;
   assign rsp_is_read_reply = read_ff;

   a_read_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_read_reply |-> !rsp_drive_update)
      else $error("read response flags a drive update");

   a_set_drives: assert property (@(posedge clock) disable iff (reset)
      ctl.enable && (op_ff == rlf_pkg::OP_SET) |=> rsp_valid && rsp_drive_update)
      else $error("set transaction did not flag a drive update");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> in_valid_ff)
      else $error("accepted request not held in input register");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while response register can drain");

endmodule

`default_nettype wire

[verif/fader_level_checker.sv]
// fader_level_checker: watches the request and response channels of rgb_linear_fader,
// predicts each response from its own copy of the channel state and compares in order.
// Depends on rlf_pkg for the op codes and the fixed-point widths.
`timescale 1ns / 1ps

module fader_level_checker
   import rlf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_op,
   input  logic [7:0] req_red_in,
   input  logic [7:0] req_green_in,
   input  logic [7:0] req_blue_in,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_red_level,
   input  logic [7:0] rsp_green_level,
   input  logic [7:0] rsp_blue_level,
   input  logic       rsp_drive_update,
   input  logic       rsp_is_read_reply,
   output int         mismatch_count,
   output int         pending_count,
   output int         checked_count,
   output int         drive_count
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       drive_update;
      logic       is_read_reply;
   } level_report_t;

   logic [LVL_W-1:0]  level_q [3];
   logic [7:0]        goal [3];
   logic [RATE_W-1:0] rate [3];

   level_report_t expected_levels[$];
   int errors;
   int checked;
   int driven;

   function automatic logic [7:0] round_level(logic [LVL_W-1:0] lvl);
      logic [LVL_W:0] sum;
      sum = ({1'b0, lvl} + LVL_HALF) >> FRAC_BITS;
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   // Applies one transaction to the channel state and returns the response it causes.
   function automatic level_report_t advance_fader(op_type op, logic [7:0] r,
                                                    logic [7:0] g, logic [7:0] b);
      logic [7:0]      chan_in [3];
      logic [7:0]      lvl_out [3];
      level_report_t   rep;
      logic            moved;
      logic [LVL_W:0]  rise;
      longint unsigned cur;
      longint unsigned aim;
      longint unsigned gap;
      logic [7:0]      rnd;
      chan_in[0] = r;
      chan_in[1] = g;
      chan_in[2] = b;
      moved = 1'b0;
      for (int c = 0; c < 3; c++) begin
         case (op)
            OP_SET: begin
               level_q[c] = LVL_W'(chan_in[c]) << FRAC_BITS;
               goal[c] = chan_in[c];
            end
            OP_FADE: begin
               cur = level_q[c];
               aim = chan_in[c];
               aim = aim << FRAC_BITS;
               gap = (cur > aim) ? cur - aim : aim - cur;
               rate[c] = RATE_W'(gap / FADE_STEPS);
               goal[c] = chan_in[c];
            end
            OP_TICK: begin
               rnd = round_level(level_q[c]);
               if (rnd > goal[c]) begin
                  if (level_q[c] > rate[c])
                     level_q[c] = level_q[c] - rate[c];
                  else
                     level_q[c] = '0;
                  moved = 1'b1;
               end else if (rnd < goal[c]) begin
                  rise = {1'b0, level_q[c]} + rate[c];
                  level_q[c] = (rise > LVL_MAX) ? LVL_MAX : rise[LVL_W-1:0];
                  moved = 1'b1;
               end
            end
            default: ;
         endcase
      end
      for (int c = 0; c < 3; c++)
         lvl_out[c] = (op == OP_READ) ? level_q[c][LVL_W-1 -: 8] : round_level(level_q[c]);
      rep.red           = lvl_out[0];
      rep.green         = lvl_out[1];
      rep.blue          = lvl_out[2];
      rep.drive_update  = (op == OP_SET) || moved;
      rep.is_read_reply = (op == OP_READ);
      return rep;
   endfunction

   task automatic check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      level_report_t want;
      if (reset) begin
         for (int c = 0; c < 3; c++) begin
            level_q[c] = '0;
            goal[c] = '0;
            rate[c] = '0;
         end
         expected_levels.delete();
         errors = 0;
         checked = 0;
         driven = 0;
      end else begin
         // push first so a same-edge response still finds its transaction
         if (req_valid && !req_stall)
            expected_levels.push_back(advance_fader(op_type'(req_op), req_red_in,
                                                    req_green_in, req_blue_in));
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               $error("response with no transaction outstanding");
               errors++;
            end else begin
               want = expected_levels.pop_front();
               check_field("red_level", want.red, rsp_red_level);
               check_field("green_level", want.green, rsp_green_level);
               check_field("blue_level", want.blue, rsp_blue_level);
               check_field("drive_update", 8'(want.drive_update), 8'(rsp_drive_update));
               check_field("is_read_reply", 8'(want.is_read_reply), 8'(rsp_is_read_reply));
               checked++;
               if (want.drive_update)
                  driven++;
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_levels.size();
      checked_count  <= checked;
      drive_count    <= driven;
   end

endmodule

[verif/tb_top.sv]
// tb_top: clock, reset and stimulus for rgb_linear_fader, with random idling on both
// channels and one long response hold. Depends on rlf_pkg, the RTL and fader_level_checker.
`timescale 1ns / 1ps

module tb_top;
   import rlf_pkg::*;

   localparam int RANDOM_ITEMS = 950;
   localparam int QUIET_FROM   = 880;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = OP_READ;
   logic [7:0] req_red_in = '0;
   logic [7:0] req_green_in = '0;
   logic [7:0] req_blue_in = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_red_level;
   logic [7:0] rsp_green_level;
   logic [7:0] rsp_blue_level;
   logic       rsp_drive_update;
   logic       rsp_is_read_reply;

   int mismatch_count;
   int pending_count;
   int checked_count;
   int drive_count;
   int accepted_items = 0;
   int cycle_count = 0;
   int op_hits [4] = '{default: 0};
   logic quiet_phase = 1'b0;

   rgb_linear_fader DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red_level(rsp_red_level),
      .rsp_green_level(rsp_green_level),
      .rsp_blue_level(rsp_blue_level),
      .rsp_drive_update(rsp_drive_update),
      .rsp_is_read_reply(rsp_is_read_reply)
   );

   fader_level_checker u_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_red_in(req_red_in),
      .req_green_in(req_green_in),
      .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_red_level(rsp_red_level),
      .rsp_green_level(rsp_green_level),
      .rsp_blue_level(rsp_blue_level),
      .rsp_drive_update(rsp_drive_update),
      .rsp_is_read_reply(rsp_is_read_reply),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count),
      .checked_count(checked_count),
      .drive_count(drive_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_command(op_type op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int idle;
      idle = 0;
      if (!quiet_phase && $urandom_range(0, 5) == 0)
         idle = $urandom_range(1, 4);
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      accepted_items <= accepted_items + 1;
      op_hits[int'(op)]++;
      if (accepted_items >= QUIET_FROM)
         quiet_phase <= 1'b1;
   endtask

   task automatic send_random(op_type op);
      send_command(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
   endtask

   initial begin : response_stall
      bit held;
      held = 1'b0;
      forever begin
         if (quiet_phase) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if (!held && accepted_items >= HOLD_AT) begin
            // long hold so the block fills and pushes back on requests
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int pick;
      int ticks;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(OP_READ, 8'd255, 8'd0, 8'd255);
      send_command(OP_TICK, 8'd0, 8'd255, 8'd0);
      send_command(OP_SET, 8'd255, 8'd255, 8'd255);
      send_command(OP_READ, 8'd0, 8'd0, 8'd0);
      send_command(OP_SET, 8'd0, 8'd0, 8'd0);
      send_command(OP_FADE, 8'd255, 8'd128, 8'd1);
      send_command(OP_TICK, 8'd255, 8'd255, 8'd255);
      send_command(OP_TICK, 8'd0, 8'd0, 8'd0);
      send_command(OP_READ, 8'd170, 8'd85, 8'd170);
      send_command(OP_FADE, 8'd0, 8'd0, 8'd0);
      send_command(OP_TICK, 8'd85, 8'd170, 8'd85);
      send_command(OP_READ, 8'd0, 8'd0, 8'd0);
      // fade to the level already held: zero rate
      send_command(OP_SET, 8'd77, 8'd77, 8'd77);
      send_command(OP_FADE, 8'd77, 8'd77, 8'd77);
      send_command(OP_TICK, 8'd0, 8'd0, 8'd0);
      // set keeps the zero rate while the targets move
      send_command(OP_SET, 8'd200, 8'd0, 8'd128);
      send_command(OP_TICK, 8'd0, 8'd0, 8'd0);
      send_command(OP_SET, 8'd255, 8'd0, 8'd255);
      send_command(OP_FADE, 8'd0, 8'd255, 8'd0);
      send_command(OP_TICK, 8'd0, 8'd0, 8'd0);
      send_command(OP_TICK, 8'd0, 8'd0, 8'd0);
      send_command(OP_SET, 8'd1, 8'd254, 8'd1);
      send_command(OP_TICK, 8'd0, 8'd0, 8'd0);
      send_command(OP_READ, 8'd0, 8'd0, 8'd0);

      while (accepted_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            send_random(OP_FADE);
            ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 280)
                                                 : $urandom_range(1, 40);
            repeat (ticks) begin
               if (accepted_items < RANDOM_ITEMS) begin
                  if ($urandom_range(0, 9) == 0)
                     send_random(OP_READ);
                  else
                     send_random(OP_TICK);
               end
            end
         end else if (pick < 80) begin
            send_random(OP_SET);
            repeat ($urandom_range(1, 6)) send_random(OP_TICK);
            send_random(OP_READ);
         end else begin
            repeat ($urandom_range(1, 8)) send_random(op_type'(2'($urandom_range(0, 3))));
         end
      end
      req_valid <= 1'b0;

      while (pending_count != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);

      $display("ran %0d transactions: %0d set, %0d fade, %0d read, %0d tick",
               op_hits[0] + op_hits[1] + op_hits[2] + op_hits[3],
               op_hits[OP_SET], op_hits[OP_FADE], op_hits[OP_READ], op_hits[OP_TICK]);
      $display("compared %0d responses, %0d with a drive update, %0d mismatches",
               checked_count, drive_count, mismatch_count);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
